// ===== rtl/rrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Region record checker package
// Shared constants, error and section codes, and the item types of the
// request and result channels.
// ----------------------------------------------------------------------------
package rrc_pkg;

   localparam int NAME_MAX   = 64;
   localparam int DESC_MAX   = 64;
   localparam int RECORD_MAX = 160;
   localparam int HDR_LEN    = 32;

   localparam logic [31:0] REC_MAGIC = 32'h4d53_5250;
   localparam logic [8:0]  POS_SAT   = 9'd511;

   localparam logic [31:0] VERSION_RESET   = 32'd1;
   localparam logic [7:0]  KIND_MASK_RESET = 8'd7;

   localparam logic [0:0] CSR_EXPECTED_VERSION = 1'd0;
   localparam logic [0:0] CSR_KIND_VALID_MASK  = 1'd1;

   localparam logic [1:0] SEC_HEADER = 2'd0;
   localparam logic [1:0] SEC_NAME   = 2'd1;
   localparam logic [1:0] SEC_DESC   = 2'd2;
   localparam logic [1:0] SEC_BEYOND = 2'd3;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_LENGTH     = 4'd1;
   localparam logic [3:0] ERR_MAGIC      = 4'd2;
   localparam logic [3:0] ERR_VERSION    = 4'd3;
   localparam logic [3:0] ERR_RESERVED   = 4'd4;
   localparam logic [3:0] ERR_NAME_LEN   = 4'd5;
   localparam logic [3:0] ERR_DESC_LEN   = 4'd6;
   localparam logic [3:0] ERR_ZERO_REGION = 4'd7;
   localparam logic [3:0] ERR_KIND       = 4'd8;
   localparam logic [3:0] ERR_NAME_CHARS = 4'd9;

   localparam logic [7:0] CHAR_DASH       = 8'h2d;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_DOT        = 8'h2e;
   localparam logic [7:0] CHAR_COLON      = 8'h3a;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [1:0]  section;
      logic [7:0]  section_offset;
      logic        done_res;
      logic        record_ok;
      logic [3:0]  error_code;
      logic [2:0]  region_kind;
      logic [63:0] region_length;
      logic [5:0]  name_length;
      logic [6:0]  descriptor_length;
   } rsp_type;

endpackage

// ===== rtl/rrc_scan.sv =====
// ----------------------------------------------------------------------------
// Region record scanner
// Holds the per-record state and the configuration registers, and forms the
// result of the byte at its input in the same cycle.
// ----------------------------------------------------------------------------
module rrc_scan (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rrc_pkg::req_type item,
   input  logic             csr_write_enable,
   input  logic [0:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output rrc_pkg::rsp_type result
);
   import rrc_pkg::*;

   logic [31:0] expected_version_ff;
   logic [7:0]  kind_mask_ff;

   logic [8:0]  pos_ff, pos_in;
   logic        magic_ok_ff, magic_ok_in;
   logic        version_ok_ff, version_ok_in;
   logic        reserved_ok_ff, reserved_ok_in;
   logic [31:0] name_len_ff, name_len_in;
   logic [31:0] desc_len_ff, desc_len_in;
   logic [31:0] kind_ff, kind_in;
   logic [63:0] region_len_ff, region_len_in;
   logic        name_chars_ok_ff, name_chars_ok_in;
   logic        nul_seen_ff, nul_seen_in;

   logic        magic_ok_upd, version_ok_upd, reserved_ok_upd;
   logic [31:0] name_len_upd, desc_len_upd, kind_upd;
   logic [63:0] region_len_upd;
   logic        name_chars_ok_upd, nul_seen_upd;

   logic [7:0]  b;
   logic [8:0]  i;
   logic        name_small, desc_small;
   logic [9:0]  name_end;
   logic [10:0] rec_end;
   logic        in_header, in_name, in_desc;
   logic [8:0]  off_name;
   logic [9:0]  off_desc;
   logic [10:0] off_beyond;
   logic [9:0]  rec_len;
   logic        char_ok, kind_ok;
   logic [4:0]  byte_shift;
   logic [3:0]  err;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= VERSION_RESET;
         kind_mask_ff        <= KIND_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata;
            CSR_KIND_VALID_MASK:  kind_mask_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign b          = item.data_byte;
   assign i          = pos_ff;
   assign byte_shift = {~i[1:0], 3'b000};

   assign name_small = (name_len_ff[31:9] == '0);
   assign desc_small = (desc_len_ff[31:9] == '0);
   assign name_end   = 10'(HDR_LEN) + {1'b0, name_len_ff[8:0]};
   assign rec_end    = {1'b0, name_end} + {2'b00, desc_len_ff[8:0]};

   assign in_header = (i < 9'(HDR_LEN));
   assign in_name   = !name_small || ({1'b0, i} < name_end);
   assign in_desc   = !desc_small || ({2'b00, i} < rec_end);

   assign off_name   = i - 9'(HDR_LEN);
   assign off_desc   = {1'b0, i} - name_end;
   assign off_beyond = {2'b00, i} - rec_end;

   assign char_ok = b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
                              CHAR_DASH, CHAR_UNDERSCORE, CHAR_DOT, CHAR_COLON};

   always_comb begin
      magic_ok_upd      = magic_ok_ff;
      version_ok_upd    = version_ok_ff;
      reserved_ok_upd   = reserved_ok_ff;
      name_len_upd      = name_len_ff;
      desc_len_upd      = desc_len_ff;
      kind_upd          = kind_ff;
      region_len_upd    = region_len_ff;
      name_chars_ok_upd = name_chars_ok_ff;
      nul_seen_upd      = nul_seen_ff;
      result            = '0;
      result.byte_out   = b;

      if (in_header) begin
         result.section        = SEC_HEADER;
         result.section_offset = i[7:0];
         case (i[4:2])
            3'd0: begin
               if (b != 8'(REC_MAGIC >> byte_shift)) magic_ok_upd = 1'b0;
            end
            3'd1: begin
               if (b != 8'(expected_version_ff >> byte_shift)) version_ok_upd = 1'b0;
            end
            3'd2: name_len_upd = {name_len_ff[23:0], b};
            3'd3: desc_len_upd = {desc_len_ff[23:0], b};
            3'd4: kind_upd = {kind_ff[23:0], b};
            3'd5: begin
               if (b != 8'd0) reserved_ok_upd = 1'b0;
            end
            default: region_len_upd = {region_len_ff[55:0], b};
         endcase
      end else if (in_name) begin
         result.section        = SEC_NAME;
         result.section_offset = off_name[8] ? 8'hff : off_name[7:0];
         if (!nul_seen_ff) begin
            if (b == 8'd0) begin
               nul_seen_upd = 1'b1;
               if (i == 9'(HDR_LEN)) name_chars_ok_upd = 1'b0;
            end else if (!char_ok) begin
               name_chars_ok_upd = 1'b0;
            end
         end
      end else if (in_desc) begin
         result.section        = SEC_DESC;
         result.section_offset = (off_desc[9:8] != 2'b00) ? 8'hff : off_desc[7:0];
      end else begin
         result.section        = SEC_BEYOND;
         result.section_offset = (off_beyond[10:8] != 3'b000) ? 8'hff : off_beyond[7:0];
      end

      rec_len = {1'b0, i} + 10'd1;
      kind_ok = (kind_upd[31:3] == '0) && kind_mask_ff[kind_upd[2:0]];

      if (rec_len < 10'(HDR_LEN) || rec_len > 10'(RECORD_MAX)) begin
         err = ERR_LENGTH;
      end else if (!magic_ok_upd) begin
         err = ERR_MAGIC;
      end else if (!version_ok_upd) begin
         err = ERR_VERSION;
      end else if (!reserved_ok_upd) begin
         err = ERR_RESERVED;
      end else if (name_len_upd == '0 || name_len_upd >= 32'(NAME_MAX)) begin
         err = ERR_NAME_LEN;
      end else if (desc_len_upd == '0 || desc_len_upd > 32'(DESC_MAX)) begin
         err = ERR_DESC_LEN;
      end else if (!(name_small && desc_small && rec_end == {1'b0, rec_len})) begin
         err = ERR_LENGTH;
      end else if (region_len_upd == '0) begin
         err = ERR_ZERO_REGION;
      end else if (!kind_ok) begin
         err = ERR_KIND;
      end else if (!name_chars_ok_upd) begin
         err = ERR_NAME_CHARS;
      end else begin
         err = ERR_NONE;
      end

      if (item.last_byte) begin
         result.done_res   = 1'b1;
         result.error_code = err;
         if (err == ERR_NONE) begin
            result.record_ok         = 1'b1;
            result.region_kind       = kind_upd[2:0];
            result.region_length     = region_len_upd;
            result.name_length       = name_len_upd[5:0];
            result.descriptor_length = desc_len_upd[6:0];
         end
      end
   end

   always_comb begin
      if (item.last_byte) begin
         pos_in           = '0;
         magic_ok_in      = 1'b1;
         version_ok_in    = 1'b1;
         reserved_ok_in   = 1'b1;
         name_len_in      = '0;
         desc_len_in      = '0;
         kind_in          = '0;
         region_len_in    = '0;
         name_chars_ok_in = 1'b1;
         nul_seen_in      = 1'b0;
      end else begin
         pos_in           = (pos_ff == POS_SAT) ? pos_ff : pos_ff + 9'd1;
         magic_ok_in      = magic_ok_upd;
         version_ok_in    = version_ok_upd;
         reserved_ok_in   = reserved_ok_upd;
         name_len_in      = name_len_upd;
         desc_len_in      = desc_len_upd;
         kind_in          = kind_upd;
         region_len_in    = region_len_upd;
         name_chars_ok_in = name_chars_ok_upd;
         nul_seen_in      = nul_seen_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         magic_ok_ff      <= 1'b1;
         version_ok_ff    <= 1'b1;
         reserved_ok_ff   <= 1'b1;
         name_len_ff      <= '0;
         desc_len_ff      <= '0;
         kind_ff          <= '0;
         region_len_ff    <= '0;
         name_chars_ok_ff <= 1'b1;
         nul_seen_ff      <= 1'b0;
      end else if (accept) begin
         pos_ff           <= pos_in;
         magic_ok_ff      <= magic_ok_in;
         version_ok_ff    <= version_ok_in;
         reserved_ok_ff   <= reserved_ok_in;
         name_len_ff      <= name_len_in;
         desc_len_ff      <= desc_len_in;
         kind_ff          <= kind_in;
         region_len_ff    <= region_len_in;
         name_chars_ok_ff <= name_chars_ok_in;
         nul_seen_ff      <= nul_seen_in;
      end
   end

endmodule

// ===== rtl/region_record_checker.sv =====
// ----------------------------------------------------------------------------
// Region record checker
// Checks a region descriptor record one byte per item and answers each byte
// with one result item.
//
// The request channel carries one record byte and a flag that marks the last
// byte of the record. Each result item echoes the byte with its section and
// its offset in that section; the result of the last byte also carries the
// verdict, the error code and the decoded header fields.
// The configuration port sets the expected version and the accepted memory
// kinds; the user writes it only while no record is in flight, and the
// block does not enforce this. The result of a byte is valid in the cycle
// after the byte is accepted. Throughput, while the receiver does not stall,
// is one item per cycle, set by the single result register after the scanner.
// When the receiver stalls, the held result stays in the result register and
// the request channel is not ready until that result is taken; a result that
// is taken frees room for the next item in the same cycle.
// Reset clears the record state, empties the result register and loads the
// configuration registers with version one and memory kinds zero to two.
// ----------------------------------------------------------------------------
module region_record_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrc_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [0:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import rrc_pkg::*;

   logic    accept;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rrc_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .item             (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .result           (result)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
